/* sv/mrpt_pkg.sv */
// Package for the Miller-Rabin prime test unit: widths, fixed bases and
// the constants of the witness-table generator. No dependencies.
`default_nettype none
package mrpt_pkg;
  localparam int NUMBER_WIDTH      = 63;
  localparam int RANDOM_ROUNDS_MAX = 63;

  localparam int NW   = NUMBER_WIDTH;
  localparam int CNTW = $clog2(NW);                  // multiply bit counter
  localparam int PW   = $clog2(NW + 1);              // bit position counter
  localparam int LW   = $clog2(RANDOM_ROUNDS_MAX + 1); // extra round index
  localparam int WAW  = $clog2(RANDOM_ROUNDS_MAX);   // witness table address

  localparam int NUM_FIXED = 8;
  localparam int FIXW      = $clog2(NUM_FIXED);
  localparam logic [NW-1:0] FIXED_BASES [NUM_FIXED] = '{
    NW'(2), NW'(3), NW'(5), NW'(7), NW'(11), NW'(13), NW'(17), NW'(19)
  };

  // Twister constants
  localparam int            MT_WW     = 32;
  localparam int            RCW       = $clog2(MT_WW + 1);
  localparam int            MT_M      = 397;
  localparam int            MT_LAST   = MT_M + RANDOM_ROUNDS_MAX - 1;
  localparam int            MT_JW     = $clog2(MT_LAST + 1);
  localparam int            MT_AW     = $clog2(RANDOM_ROUNDS_MAX + 1);
  localparam logic [31:0]   MT_SEED   = 32'd239;
  localparam logic [31:0]   MT_MULT   = 32'd1812433253;
  localparam logic [31:0]   MT_MATRIX = 32'h9908b0df;
  localparam logic [31:0]   MT_TMASK_B = 32'h9d2c5680;
  localparam logic [31:0]   MT_TMASK_C = 32'hefc60000;
endpackage
`default_nettype wire

/* sv/mrpt_modmul.sv */
// Bit-serial modular multiplier (shift and add, one multiplier bit a cycle).
// Depends on mrpt_pkg.
`default_nettype none
module mrpt_modmul import mrpt_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] opa,
  input  wire logic [NW-1:0] opb,
  input  wire logic [NW-1:0] modulus,
  output logic               done,
  output logic [NW-1:0]      product
);
  logic [NW-1:0]   addend;
  logic [NW-1:0]   mult;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [NW:0]     sum_acc, sum_dbl;
  logic [NW-1:0]   acc_next, dbl_next;

  // two independent modular adds: accumulate and double
  always_comb begin
    sum_acc  = {1'b0, product} + {1'b0, addend};
    sum_dbl  = {1'b0, addend} + {1'b0, addend};
    acc_next = (sum_acc >= {1'b0, modulus}) ? NW'(sum_acc - {1'b0, modulus})
                                            : sum_acc[NW-1:0];
    dbl_next = (sum_dbl >= {1'b0, modulus}) ? NW'(sum_dbl - {1'b0, modulus})
                                            : sum_dbl[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        product <= '0;
        addend  <= opa;
        mult    <= opb;
      end else if (busy) begin
        if (mult[0]) product <= acc_next;
        addend <= dbl_next;
        mult   <= mult >> 1;
        if (cnt == CNTW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* sv/mrpt_mtgen.sv */
// Witness table: runs the 32-bit twister seeded with 239 once after reset
// and keeps its first outputs in a memory. Depends on mrpt_pkg.
`default_nettype none
module mrpt_mtgen import mrpt_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [WAW-1:0] rd_addr,
  output logic [31:0]         rd_data,
  output logic                ready
);
  logic [31:0] amem [RANDOM_ROUNDS_MAX + 1];
  logic [31:0] wmem [RANDOM_ROUNDS_MAX];
  logic [MT_JW-1:0] j;
  logic             phase;
  logic [31:0] cur, prod, a_q, a_hold;
  logic [31:0] stj, y, v, t1, t2, t3, t4;
  logic [MT_JW-1:0] rd_off, w_off;
  logic        twist_we, a_we;

  // state word for this step, twist and tempering
  always_comb begin
    stj    = (j == '0) ? MT_SEED : prod + 32'(j);
    rd_off = j - MT_JW'(MT_M - 1);
    w_off  = j - MT_JW'(MT_M);
    y      = {a_hold[31], a_q[30:0]};
    v      = stj ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'd0);
    t1     = v ^ (v >> 11);
    t2     = t1 ^ ((t1 << 7) & MT_TMASK_B);
    t3     = t2 ^ ((t2 << 15) & MT_TMASK_C);
    t4     = t3 ^ (t3 >> 18);
    a_we     = !ready && phase && (j <= MT_JW'(RANDOM_ROUNDS_MAX));
    twist_we = !ready && phase && (j >= MT_JW'(MT_M));
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      j     <= '0;
      phase <= 1'b0;
      ready <= 1'b0;
    end else if (!ready) begin
      phase <= !phase;
      if (!phase) begin
        prod <= MT_MULT * (cur ^ (cur >> 30));
      end else begin
        cur <= stj;
        if (j >= MT_JW'(MT_M - 1)) a_hold <= a_q;
        if (j == MT_JW'(MT_LAST)) ready <= 1'b1;
        else j <= j + 1'b1;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (a_we) amem[j[MT_AW-1:0]] <= stj;
    if (!phase && j >= MT_JW'(MT_M - 1)) a_q <= amem[rd_off[MT_AW-1:0]];
    if (twist_we) wmem[w_off[WAW-1:0]] <= t4;
    rd_data <= wmem[rd_addr];
  end
endmodule
`default_nettype wire

/* sv/miller_rabin_prime_test_unit.sv */
// Miller-Rabin prime test unit: top level, round sequencer and exponentiation.
// Depends on mrpt_pkg, mrpt_modmul and mrpt_mtgen.
//
// Use: one candidate transaction enters on in_valid/in_ready (candidate);
// one result transaction leaves on out_valid/out_ready (prime_flag).
// The unit handles one candidate at a time. 0, 1 and even numbers are
// answered straight from the idle state. An odd candidate runs up to 8
// fixed-base rounds and then one round per bit of its length (at most 71
// rounds). Each round is a left-to-right exponentiation over at most 63
// exponent bits, each bit one or two modular multiplies in the bit-serial
// multiplier. A composite usually stops early. After reset the witness
// table is built from the twister over 460 state words; in_ready stays
// low until it is done. A result waits in its output register while
// out_ready is low, and no new candidate is taken until it has been
// delivered.
`default_nettype none
module miller_rabin_prime_test_unit import mrpt_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [NW-1:0] candidate,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               prime_flag
);
  typedef enum logic [3:0] {
    S_IDLE, S_LEN, S_ROUND, S_WRD, S_RED, S_SQ, S_SQW, S_ML, S_MLW, S_CHK
  } state_t;

  state_t        state;
  logic [NW-1:0] n, nm1, x, a, t, e_rest, red_r;
  logic [31:0]   red_w;
  logic [RCW-1:0] red_cnt;
  logic [PW-1:0] pcnt;
  logic [LW-1:0] len, k;
  logic          fixed_ph, zero_seen;
  logic          tbl_ready;
  logic [31:0]   w_data;
  logic          mm_start, mm_done;
  logic [NW-1:0] mm_prod, mm_opb;
  logic [NW:0]   red_t;
  logic [NW-1:0] red_next, rest_next;
  logic [PW-1:0] pnew;

  mrpt_mtgen u_mtgen (
    .clk, .rst,
    .rd_addr (k[WAW-1:0]),
    .rd_data (w_data),
    .ready   (tbl_ready)
  );

  assign mm_start = (state == S_SQ) || (state == S_ML);
  assign mm_opb   = (state == S_ML) ? a : x;

  mrpt_modmul u_modmul (
    .clk, .rst,
    .start   (mm_start),
    .opa     (x),
    .opb     (mm_opb),
    .modulus (n),
    .done    (mm_done),
    .product (mm_prod)
  );

  assign in_ready = (state == S_IDLE) && !out_valid && tbl_ready;

  // witness reduction step and exponent scan step
  always_comb begin
    red_t     = {red_r, red_w[31]};
    red_next  = (red_t >= {1'b0, nm1}) ? NW'(red_t - {1'b0, nm1}) : red_t[NW-1:0];
    rest_next = e_rest << 1;
    pnew      = pcnt - 1'b1;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            n        <= candidate;
            nm1      <= candidate - 1'b1;
            t        <= candidate;
            len      <= '0;
            k        <= '0;
            fixed_ph <= 1'b1;
            if (candidate < NW'(2)) begin
              out_valid  <= 1'b1;
              prime_flag <= 1'b0;
            end else if (!candidate[0]) begin
              out_valid  <= 1'b1;
              prime_flag <= (candidate == NW'(2));
            end else begin
              state <= S_LEN;
            end
          end
        end
        S_LEN: begin
          if (t == '0 || len == LW'(RANDOM_ROUNDS_MAX)) begin
            state <= S_ROUND;
          end else begin
            t   <= t >> 1;
            len <= len + 1'b1;
          end
        end
        S_ROUND: begin
          x         <= NW'(1);
          e_rest    <= nm1;
          pcnt      <= PW'(NW);
          zero_seen <= 1'b0;
          if (fixed_ph) begin
            if (FIXED_BASES[k[FIXW-1:0]] >= n) begin
              // base not below n: round passes
              if (k == LW'(NUM_FIXED - 1)) begin
                fixed_ph <= 1'b0;
                k        <= '0;
              end else begin
                k <= k + 1'b1;
              end
            end else begin
              a     <= FIXED_BASES[k[FIXW-1:0]];
              state <= S_SQ;
            end
          end else if (k == len) begin
            out_valid  <= 1'b1;
            prime_flag <= 1'b1;
            state      <= S_IDLE;
          end else begin
            state <= S_WRD;
          end
        end
        S_WRD: begin
          red_w   <= w_data;
          red_r   <= '0;
          red_cnt <= '0;
          state   <= S_RED;
        end
        S_RED: begin
          if (red_cnt == RCW'(MT_WW)) begin
            a     <= red_r + 1'b1;
            state <= S_SQ;
          end else begin
            red_r   <= red_next;
            red_w   <= red_w << 1;
            red_cnt <= red_cnt + 1'b1;
          end
        end
        S_SQ: state <= S_SQW;
        S_SQW: begin
          if (mm_done) begin
            x     <= mm_prod;
            state <= e_rest[NW-1] ? S_ML : S_CHK;
          end
        end
        S_ML: state <= S_MLW;
        S_MLW: begin
          if (mm_done) begin
            x     <= mm_prod;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          e_rest <= rest_next;
          pcnt   <= pnew;
          if (pnew != '0 && rest_next == '0) zero_seen <= 1'b1;
          if (pnew != '0 && rest_next == '0 &&
              (x == nm1 || (!zero_seen && x == NW'(1)))) begin
            // round passed, move to the next base
            state <= S_ROUND;
            if (fixed_ph && k == LW'(NUM_FIXED - 1)) begin
              fixed_ph <= 1'b0;
              k        <= '0;
            end else begin
              k <= k + 1'b1;
            end
          end else if (pnew == '0) begin
            out_valid  <= 1'b1;
            prime_flag <= 1'b0;
            state      <= S_IDLE;
          end else begin
            state <= S_SQ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_take_while_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_table_first: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> tbl_ready) else $error("input taken before witness table");
  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> (pcnt != '0)) else $error("exponent scan overran");
`endif
endmodule
`default_nettype wire
